// ===== hdl/sugfs_pkg.sv =====
// Shared types, constants and helper functions for the stereo upmix unit.
// No dependencies; every other file of the block imports this package.
package sugfs_pkg;

    localparam int NUM_CH     = 5;
    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int PROD_W     = 48;
    localparam int ACC_W      = 56;

    localparam logic [CFG_DATA_W-1:0] GAIN_RESET = 48'd55763591770321;

    // Register map of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LPF_ENABLE  = 3'd0,
        REG_FL_GAINS    = 3'd1,
        REG_FR_GAINS    = 3'd2,
        REG_SL_GAINS    = 3'd3,
        REG_SR_GAINS    = 3'd4,
        REG_C_GAINS     = 3'd5
    } reg_idx_t;

    // Channel numbering, also the order in which channels are processed.
    localparam logic [CH_W-1:0] CH_FL   = 3'd0;
    localparam logic [CH_W-1:0] CH_FR   = 3'd1;
    localparam logic [CH_W-1:0] CH_SL   = 3'd2;
    localparam logic [CH_W-1:0] CH_SR   = 3'd3;
    localparam logic [CH_W-1:0] CH_C    = 3'd4;
    localparam logic [CH_W-1:0] CH_LAST = CH_C;

    // Operand source of one multiply-accumulate request.
    typedef enum logic [1:0] {
        SRC_MIX_L,
        SRC_MIX_R,
        SRC_TAP
    } src_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MIX_L,
        ST_MIX_R,
        ST_MIX_DRAIN,
        ST_MIX_LATCH,
        ST_FIR_ISSUE,
        ST_FIR_DRAIN,
        ST_FIR_LATCH,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath, valid for one cycle.
    typedef struct packed {
        logic            in_load;
        logic            clr_wr;
        logic            op_valid;
        src_t            op_src;
        logic            op_first;
        logic            mix_latch;
        logic            fir_latch;
        logic            out_load;
        logic [CH_W-1:0] ch;
    } cmd_t;

    // Saturation limit, 0.999 in Q1.23.
    localparam int SAT_LIMIT = 8380219;
    localparam logic signed [SAMPLE_W-1:0] SAT_HI      = 24'sd8380219;
    localparam logic signed [SAMPLE_W-1:0] SAT_LO      = -24'sd8380219;
    localparam logic signed [ACC_W-1:0]    SAT_HI_WIDE = 56'sd8380219;
    localparam logic signed [ACC_W-1:0]    SAT_LO_WIDE = -56'sd8380219;

    // Round half up before the arithmetic shift.
    localparam logic signed [ACC_W-1:0] MIX_RND   = 56'sd1048576;
    localparam int                      MIX_SHIFT = 21;
    localparam logic signed [ACC_W-1:0] FIR_RND   = 56'sd4194304;
    localparam int                      FIR_SHIFT = 23;

    // Symmetric low-pass coefficients in Q1.23.
    localparam int COEF_TABLE_LEN = 31;
    localparam int COEF_IDX_W     = 5;
    localparam logic signed [SAMPLE_W-1:0] LP_COEF [COEF_TABLE_LEN] = '{
        -24'sd2714,    24'sd5150,    -24'sd8252,   24'sd11408,   -24'sd13179,
        24'sd10860,    -24'sd22,     -24'sd25835,  24'sd75265,   -24'sd158123,
        24'sd283572,   -24'sd456275, 24'sd670256,  -24'sd900217, 24'sd1090801,
        24'sd7223215,
        24'sd1090801,  -24'sd900217, 24'sd670256,  -24'sd456275, 24'sd283572,
        -24'sd158123,  24'sd75265,   -24'sd25835,  -24'sd22,     24'sd10860,
        -24'sd13179,   24'sd11408,   -24'sd8252,   24'sd5150,    -24'sd2714
    };

    // Taps beyond the table take a zero coefficient.
    function automatic logic signed [SAMPLE_W-1:0] coef_at(input int unsigned idx);
        logic signed [SAMPLE_W-1:0] c;
        c = '0;
        if (idx < COEF_TABLE_LEN)
        begin
            c = LP_COEF[idx[COEF_IDX_W-1:0]];
        end
        return c;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_q23(input logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_HI_WIDE)
        begin
            r = SAT_HI;
        end
        else if (v < SAT_LO_WIDE)
        begin
            r = SAT_LO;
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/sugfs_ctrl.sv =====
// Controller of the stereo upmix unit: sequences the clearing pass, the mix
// and filter passes of each channel and the output register. Uses sugfs_pkg.
module sugfs_ctrl
    import sugfs_pkg::*;
#(
    parameter int TAP_COUNT = 31,
    localparam int PW       = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1,
    localparam int DEPTH    = NUM_CH * TAP_COUNT,
    localparam int ADDR_W   = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic              lpf_enable,
    output cmd_t              cmd,
    output logic [ADDR_W-1:0] mem_addr,
    output logic [PW-1:0]     coef_idx
);

    localparam logic [PW-1:0]     LAST_POS  = PW'(TAP_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] TAP_STEP  = ADDR_W'(TAP_COUNT);

    state_t            state_reg, state_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [PW-1:0]     tap_ptr_reg, tap_ptr_next;
    logic [PW-1:0]     tap_idx_reg, tap_idx_next;
    logic              drain_reg, drain_next;
    logic              out_valid_reg, out_valid_next;
    logic              slot_free;
    logic              last_ch;

    function automatic logic [PW-1:0] inc_wrap(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == LAST_POS)
        begin
            r = '0;
        end
        else
        begin
            r = PW'(p + 1'b1);
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ch_reg        <= '0;
            base_reg      <= '0;
            clr_addr_reg  <= '0;
            pos_reg       <= '0;
            tap_ptr_reg   <= '0;
            tap_idx_reg   <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            base_reg      <= base_next;
            clr_addr_reg  <= clr_addr_next;
            pos_reg       <= pos_next;
            tap_ptr_reg   <= tap_ptr_next;
            tap_idx_reg   <= tap_idx_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign last_ch   = (ch_reg == CH_LAST);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        base_next      = base_reg;
        clr_addr_next  = clr_addr_reg;
        pos_next       = pos_reg;
        tap_ptr_next   = tap_ptr_reg;
        tap_idx_next   = tap_idx_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.op_src     = SRC_MIX_L;
        cmd.ch         = ch_reg;
        mem_addr       = ADDR_W'(base_reg + ADDR_W'(pos_reg));
        coef_idx       = tap_idx_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                mem_addr   = clr_addr_reg;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = ADDR_W'(clr_addr_reg + 1'b1);
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    ch_next     = CH_FL;
                    base_next   = '0;
                    state_next  = ST_MIX_L;
                end
            end

            ST_MIX_L:
            begin
                cmd.op_valid = 1'b1;
                cmd.op_src   = SRC_MIX_L;
                cmd.op_first = 1'b1;
                state_next   = ST_MIX_R;
            end

            ST_MIX_R:
            begin
                cmd.op_valid = 1'b1;
                cmd.op_src   = SRC_MIX_R;
                drain_next   = 1'b0;
                state_next   = ST_MIX_DRAIN;
            end

            ST_MIX_DRAIN:
            begin
                if (drain_reg)
                begin
                    state_next = ST_MIX_LATCH;
                end
                else
                begin
                    drain_next = 1'b1;
                end
            end

            ST_MIX_LATCH:
            begin
                cmd.mix_latch = 1'b1;
                if (lpf_enable)
                begin
                    tap_ptr_next = inc_wrap(pos_reg);
                    tap_idx_next = LAST_POS;
                    state_next   = ST_FIR_ISSUE;
                end
                else if (last_ch)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ch_next    = CH_W'(ch_reg + 1'b1);
                    base_next  = ADDR_W'(base_reg + TAP_STEP);
                    state_next = ST_MIX_L;
                end
            end

            ST_FIR_ISSUE:
            begin
                cmd.op_valid = 1'b1;
                cmd.op_src   = SRC_TAP;
                cmd.op_first = (tap_idx_reg == LAST_POS);
                mem_addr     = ADDR_W'(base_reg + ADDR_W'(tap_ptr_reg));
                tap_ptr_next = inc_wrap(tap_ptr_reg);
                if (tap_idx_reg == '0)
                begin
                    drain_next = 1'b0;
                    state_next = ST_FIR_DRAIN;
                end
                else
                begin
                    tap_idx_next = PW'(tap_idx_reg - 1'b1);
                end
            end

            ST_FIR_DRAIN:
            begin
                if (drain_reg)
                begin
                    state_next = ST_FIR_LATCH;
                end
                else
                begin
                    drain_next = 1'b1;
                end
            end

            ST_FIR_LATCH:
            begin
                cmd.fir_latch = 1'b1;
                if (last_ch)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ch_next    = CH_W'(ch_reg + 1'b1);
                    base_next  = ADDR_W'(base_reg + TAP_STEP);
                    state_next = ST_MIX_L;
                end
            end

            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    if (lpf_enable)
                    begin
                        pos_next = inc_wrap(pos_reg);
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/sugfs_datapath.sv =====
// Datapath of the stereo upmix unit: configuration registers, the shared
// multiply-accumulate unit, the filter history memory and the result
// registers. Uses sugfs_pkg; driven by sugfs_ctrl.
module sugfs_datapath
    import sugfs_pkg::*;
#(
    parameter int TAP_COUNT = 31,
    localparam int PW       = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1,
    localparam int DEPTH    = NUM_CH * TAP_COUNT,
    localparam int ADDR_W   = $clog2(DEPTH)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cmd_t                        cmd,
    input  logic [ADDR_W-1:0]           mem_addr,
    input  logic [PW-1:0]               coef_idx,
    input  logic                        cfg_valid,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [SAMPLE_W-1:0]  left_sample,
    input  logic signed [SAMPLE_W-1:0]  right_sample,
    output logic                        lpf_enable,
    output logic signed [SAMPLE_W-1:0]  front_left_out,
    output logic signed [SAMPLE_W-1:0]  front_right_out,
    output logic signed [SAMPLE_W-1:0]  surround_left_out,
    output logic signed [SAMPLE_W-1:0]  surround_right_out,
    output logic signed [SAMPLE_W-1:0]  center_out
);

    logic                       lpf_enable_reg;
    logic [CFG_DATA_W-1:0]      gain_reg [NUM_CH];
    logic signed [SAMPLE_W-1:0] left_reg, right_reg;
    logic signed [SAMPLE_W-1:0] a_reg, b_reg, a_next, b_next;
    logic [SAMPLE_W-1:0]        rdata_reg;
    logic [SAMPLE_W-1:0]        hist_mem [DEPTH];
    logic                       s1_valid_reg, s1_first_reg, s1_tap_reg;
    logic                       s2_valid_reg, s2_first_reg;
    logic signed [SAMPLE_W-1:0] mul_b;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    mix_sum, fir_sum;
    logic signed [SAMPLE_W-1:0] mix_y, fir_y;
    logic [CFG_DATA_W-1:0]      gain_sel;
    logic signed [SAMPLE_W-1:0] work_reg [NUM_CH];
    logic signed [SAMPLE_W-1:0] out_reg [NUM_CH];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpf_enable_reg <= 1'b1;
            for (int i = 0; i < NUM_CH; i++)
            begin
                gain_reg[i] <= GAIN_RESET;
            end
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_LPF_ENABLE: lpf_enable_reg  <= cfg_data[0];
                REG_FL_GAINS:   gain_reg[CH_FL] <= cfg_data;
                REG_FR_GAINS:   gain_reg[CH_FR] <= cfg_data;
                REG_SL_GAINS:   gain_reg[CH_SL] <= cfg_data;
                REG_SR_GAINS:   gain_reg[CH_SR] <= cfg_data;
                REG_C_GAINS:    gain_reg[CH_C]  <= cfg_data;
                default:        lpf_enable_reg  <= lpf_enable_reg;
            endcase
        end
    end

    assign lpf_enable = lpf_enable_reg;
    assign gain_sel   = gain_reg[cmd.ch];

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            left_reg  <= left_sample;
            right_reg <= right_sample;
        end
    end

    // Operand selection for the multiplier.
    always_comb
    begin
        case (cmd.op_src)
            SRC_MIX_L:
            begin
                a_next = left_reg;
                b_next = signed'(gain_sel[GAIN_W-1:0]);
            end
            SRC_MIX_R:
            begin
                a_next = right_reg;
                b_next = signed'(gain_sel[CFG_DATA_W-1:GAIN_W]);
            end
            SRC_TAP:
            begin
                a_next = coef_at(32'(coef_idx));
                b_next = '0;
            end
            default:
            begin
                a_next = '0;
                b_next = '0;
            end
        endcase
    end

    // History memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            hist_mem[mem_addr] <= '0;
        end
        else if (cmd.mix_latch && lpf_enable_reg)
        begin
            hist_mem[mem_addr] <= mix_y;
        end
        rdata_reg <= hist_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_tap_reg   <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_first_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.op_valid;
            s1_first_reg <= cmd.op_first;
            s1_tap_reg   <= (cmd.op_src == SRC_TAP);
            s2_valid_reg <= s1_valid_reg;
            s2_first_reg <= s1_first_reg;
        end
    end

    assign mul_b = s1_tap_reg ? signed'(rdata_reg) : b_reg;

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        if (s1_valid_reg)
        begin
            prod_reg <= a_reg * mul_b;
        end
        if (s2_valid_reg)
        begin
            if (s2_first_reg)
            begin
                acc_reg <= ACC_W'(prod_reg);
            end
            else
            begin
                acc_reg <= ACC_W'(acc_reg + ACC_W'(prod_reg));
            end
        end
    end

    assign mix_sum = ACC_W'(acc_reg + MIX_RND) >>> MIX_SHIFT;
    assign fir_sum = ACC_W'(acc_reg + FIR_RND) >>> FIR_SHIFT;
    assign mix_y   = sat_q23(mix_sum);
    assign fir_y   = sat_q23(fir_sum);

    always_ff @(posedge clk)
    begin
        if (cmd.mix_latch)
        begin
            work_reg[cmd.ch] <= mix_y;
        end
        else if (cmd.fir_latch)
        begin
            work_reg[cmd.ch] <= fir_y;
        end
        if (cmd.out_load)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                out_reg[i] <= work_reg[i];
            end
        end
    end

    assign front_left_out     = out_reg[CH_FL];
    assign front_right_out    = out_reg[CH_FR];
    assign surround_left_out  = out_reg[CH_SL];
    assign surround_right_out = out_reg[CH_SR];
    assign center_out         = out_reg[CH_C];

endmodule

// ===== hdl/stereo_upmix_gain_fir_saturate_unit.sv =====
// Top level of the stereo to five-channel upmix unit with low-pass filter.
// Instantiates sugfs_ctrl and sugfs_datapath; uses sugfs_pkg.
//
// Usage. A request on the input channel (in_valid/in_ready) carries one
// stereo pair in Q1.23. For it the block returns one request on the output
// channel (out_valid/out_ready) holding five Q1.23 channels, each the gain
// weighted sum of left and right, clamped to plus or minus 0.999 and, when
// the filter is enabled, passed through its own symmetric low-pass FIR of
// TAP_COUNT taps and clamped again. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) is always ready, and the user must see
// that it is written only while the block is idle, which is not enforced.
// Index 0 enables the filter, indexes 1 to 5 hold the gains.
// Sequencing. All products share one 24 by 24 multiply-accumulate unit,
// so a new request is taken only once the last result has been loaded
// into the output register. Each channel costs two mix products and,
// with the filter on, TAP_COUNT filter taps; the mix pass and the filter
// pass each end with a pipeline drain and a latch of the result.
// Reset. After reset the history memory is cleared, one entry a cycle, and
// in_ready stays low until every entry is cleared.
// Stalls. The result sits in its own output register; the next input is
// accepted and processed while it waits, and only the hand-over of the next
// result waits for the receiver.
module stereo_upmix_gain_fir_saturate_unit
    import sugfs_pkg::*;
#(
    parameter int TAP_COUNT = 31
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [SAMPLE_W-1:0]  left_sample,
    input  logic signed [SAMPLE_W-1:0]  right_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  front_left_out,
    output logic signed [SAMPLE_W-1:0]  front_right_out,
    output logic signed [SAMPLE_W-1:0]  surround_left_out,
    output logic signed [SAMPLE_W-1:0]  surround_right_out,
    output logic signed [SAMPLE_W-1:0]  center_out,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    // Widths of the position counters and of the history memory address.
    localparam int PW     = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int ADDR_W = $clog2(NUM_CH * TAP_COUNT);

    cmd_t              cmd;
    logic [ADDR_W-1:0] mem_addr;
    logic [PW-1:0]     coef_idx;
    logic              lpf_enable;

    // Configuration writes go straight to registers; the port never stalls.
    assign cfg_ready = 1'b1;

    // The controller owns all sequencing; the datapath only follows commands.
    sugfs_ctrl #(
        .TAP_COUNT (TAP_COUNT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .lpf_enable (lpf_enable),
        .cmd        (cmd),
        .mem_addr   (mem_addr),
        .coef_idx   (coef_idx)
    );

    sugfs_datapath #(
        .TAP_COUNT (TAP_COUNT)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .mem_addr           (mem_addr),
        .coef_idx           (coef_idx),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .left_sample        (left_sample),
        .right_sample       (right_sample),
        .lpf_enable         (lpf_enable),
        .front_left_out     (front_left_out),
        .front_right_out    (front_right_out),
        .surround_left_out  (surround_left_out),
        .surround_right_out (surround_right_out),
        .center_out         (center_out)
    );

endmodule

// ===== hdl/sugfs_checker.sv =====
// Port-level checks for the stereo upmix unit, bound to its top level.
// Uses sugfs_pkg for the saturation limits.
module sugfs_checker
    import sugfs_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] front_left_out,
    input logic signed [SAMPLE_W-1:0] front_right_out,
    input logic signed [SAMPLE_W-1:0] surround_left_out,
    input logic signed [SAMPLE_W-1:0] surround_right_out,
    input logic signed [SAMPLE_W-1:0] center_out
);

    // A stalled result is held until the receiver takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(front_left_out) && $stable(front_right_out)
            && $stable(surround_left_out) && $stable(surround_right_out)
            && $stable(center_out))
        else $error("result changed while stalled");

    // One sample pair is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a sample pair is in progress");

    // Every delivered channel lies within the clamp limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> front_left_out <= SAT_HI && front_left_out >= SAT_LO
            && front_right_out <= SAT_HI && front_right_out >= SAT_LO
            && surround_left_out <= SAT_HI && surround_left_out >= SAT_LO
            && surround_right_out <= SAT_HI && surround_right_out >= SAT_LO
            && center_out <= SAT_HI && center_out >= SAT_LO)
        else $error("output outside the clamp limits");

endmodule

bind stereo_upmix_gain_fir_saturate_unit sugfs_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .front_left_out     (front_left_out),
    .front_right_out    (front_right_out),
    .surround_left_out  (surround_left_out),
    .surround_right_out (surround_right_out),
    .center_out         (center_out)
);

// ===== verif/upmix_checker.sv =====
`timescale 1ns / 1ps
// Checker for the stereo upmix unit: watches the input, output and register
// channels, predicts the five output channels of every stereo pair and compares.
// Depends on sugfs_pkg for the widths and the register map.
module upmix_checker
    import sugfs_pkg::*;
#(
    parameter int TAP_COUNT = 31
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic signed [SAMPLE_W-1:0]  left_sample,
    input  logic signed [SAMPLE_W-1:0]  right_sample,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic signed [SAMPLE_W-1:0]  front_left_out,
    input  logic signed [SAMPLE_W-1:0]  front_right_out,
    input  logic signed [SAMPLE_W-1:0]  surround_left_out,
    input  logic signed [SAMPLE_W-1:0]  surround_right_out,
    input  logic signed [SAMPLE_W-1:0]  center_out,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output int                          outstanding,
    output int                          error_count,
    output int                          results_checked
);

    // Index 0 is front left, 4 is center.
    typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] five_ch_t;

    localparam int FULL_SCALE    = 8380219;
    localparam int TAP_TABLE_LEN = 31;
    localparam int LOWPASS_TAP [TAP_TABLE_LEN] = '{
        -2714, 5150, -8252, 11408, -13179, 10860, -22, -25835,
        75265, -158123, 283572, -456275, 670256, -900217, 1090801,
        7223215,
        1090801, -900217, 670256, -456275, 283572, -158123, 75265,
        -25835, -22, 10860, -13179, 11408, -8252, 5150, -2714
    };

    logic                  filter_on;
    logic [CFG_DATA_W-1:0] mix_gains [NUM_CH];
    int                    history [NUM_CH][TAP_COUNT];
    int                    slot;
    five_ch_t              pending_outputs [$];
    int                    mismatches = 0;
    int                    seen = 0;

    function automatic int clamp_full_scale(input longint v);
        if (v > FULL_SCALE)
            return FULL_SCALE;
        if (v < -FULL_SCALE)
            return -FULL_SCALE;
        return int'(v);
    endfunction

    // Mix, round and clamp each channel, then run it through its own history
    // when the filter is on. The newest sample meets the first coefficient.
    function automatic five_ch_t predict_upmix(input logic signed [SAMPLE_W-1:0] l,
                                               input logic signed [SAMPLE_W-1:0] r);
        five_ch_t res;
        longint   gl, gr, mix, acc;
        int       y, p, c, k, coef_idx;
        for (c = 0; c < NUM_CH; c++)
        begin
            gl  = $signed(mix_gains[c][GAIN_W-1:0]);
            gr  = $signed(mix_gains[c][2*GAIN_W-1:GAIN_W]);
            mix = l * gl + r * gr;
            y   = clamp_full_scale((mix + 64'sd1048576) >>> 21);
            if (filter_on)
            begin
                history[c][slot] = y;
                p   = (slot + 1 >= TAP_COUNT) ? 0 : slot + 1;
                acc = 0;
                for (k = 0; k < TAP_COUNT; k++)
                begin
                    coef_idx = TAP_COUNT - 1 - k;
                    if (coef_idx < TAP_TABLE_LEN)
                        acc += longint'(LOWPASS_TAP[coef_idx]) * history[c][p];
                    p = (p + 1 >= TAP_COUNT) ? 0 : p + 1;
                end
                y = clamp_full_scale((acc + 64'sd4194304) >>> 23);
            end
            res[c] = y[SAMPLE_W-1:0];
        end
        if (filter_on)
            slot = (slot + 1 >= TAP_COUNT) ? 0 : slot + 1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        five_ch_t got, want;
        int       ch, k;
        if (!rst_n)
        begin
            filter_on = 1'b1;
            slot      = 0;
            for (ch = 0; ch < NUM_CH; ch++)
            begin
                mix_gains[ch] = GAIN_RESET;
                for (k = 0; k < TAP_COUNT; k++)
                    history[ch][k] = 0;
            end
            pending_outputs.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LPF_ENABLE:
                        filter_on = cfg_data[0];
                    REG_FL_GAINS, REG_FR_GAINS, REG_SL_GAINS, REG_SR_GAINS, REG_C_GAINS:
                        mix_gains[cfg_index - REG_FL_GAINS] = cfg_data;
                    default:
                        ;
                endcase
            end
            if (in_valid && in_ready)
                pending_outputs.push_back(predict_upmix(left_sample, right_sample));
            if (out_valid && out_ready)
            begin
                got = {center_out, surround_right_out, surround_left_out,
                       front_right_out, front_left_out};
                seen++;
                if (pending_outputs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with no stereo pair waiting", seen);
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    for (ch = 0; ch < NUM_CH; ch++)
                    begin
                        if (got[ch] !== want[ch])
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("result %0d channel %0d: expected %0d, got %0d",
                                         seen, ch, $signed(want[ch]), $signed(got[ch]));
                        end
                    end
                end
            end
            outstanding <= pending_outputs.size();
        end
        error_count     <= mismatches;
        results_checked <= seen;
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Top of the upmix unit regression: clock, reset, stimulus and the verdict.
// Depends on sugfs_pkg, stereo_upmix_gain_fir_saturate_unit and upmix_checker.
module tb;
    import sugfs_pkg::*;

    localparam int TAP_COUNT   = 31;
    // One request keeps the block busy for this many cycles with the filter on.
    localparam int ITEM_CYCLES = 5 * (TAP_COUNT + 8) + 2;
    localparam int HOLD_CYCLES = 8 * ITEM_CYCLES;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_PAIRS = 160;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;
    localparam logic [GAIN_W-1:0] GAIN_MAX     = 24'h7FFFFF;
    localparam logic [GAIN_W-1:0] GAIN_MIN     = 24'h800000;
    localparam logic [GAIN_W-1:0] GAIN_NEG_LSB = 24'hFFFFFF;
    localparam logic [GAIN_W-1:0] GAIN_UNITY   = 24'h200000;

    // The two indexes above the register map, which the block must ignore.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam reg_idx_t GAIN_REG [NUM_CH] = '{
        REG_FL_GAINS, REG_FR_GAINS, REG_SL_GAINS, REG_SR_GAINS, REG_C_GAINS
    };

    logic                        clk;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic                        in_ready;
    logic signed [SAMPLE_W-1:0]  left_sample  = '0;
    logic signed [SAMPLE_W-1:0]  right_sample = '0;
    logic                        out_valid;
    logic                        out_ready    = 1'b0;
    logic signed [SAMPLE_W-1:0]  front_left_out;
    logic signed [SAMPLE_W-1:0]  front_right_out;
    logic signed [SAMPLE_W-1:0]  surround_left_out;
    logic signed [SAMPLE_W-1:0]  surround_right_out;
    logic signed [SAMPLE_W-1:0]  center_out;
    logic                        cfg_valid    = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index    = '0;
    logic [CFG_DATA_W-1:0]       cfg_data     = '0;

    int   outstanding;
    int   error_count;
    int   results_checked;

    // Idle and stall rates in percent. The sender's rate belongs to the
    // stimulus process alone; the receiver's is handed over by assignment at
    // the clock edge so that the receiver process never races it.
    int   sender_idle_pct = 0;
    int   stall_pct       = 0;
    logic hold_req        = 1'b0;
    logic hold_req_q      = 1'b0;
    int   hold_left       = 0;

    int   cycle_count = 0;
    int   pairs_sent  = 0;
    int   reg_writes  = 0;

    stereo_upmix_gain_fir_saturate_unit #(
        .TAP_COUNT(TAP_COUNT)
    ) u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .left_sample        (left_sample),
        .right_sample       (right_sample),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .front_left_out     (front_left_out),
        .front_right_out    (front_right_out),
        .surround_left_out  (surround_left_out),
        .surround_right_out (surround_right_out),
        .center_out         (center_out),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    upmix_checker #(
        .TAP_COUNT(TAP_COUNT)
    ) u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .left_sample        (left_sample),
        .right_sample       (right_sample),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .front_left_out     (front_left_out),
        .front_right_out    (front_right_out),
        .surround_left_out  (surround_left_out),
        .surround_right_out (surround_right_out),
        .center_out         (center_out),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .outstanding        (outstanding),
        .error_count        (error_count),
        .results_checked    (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("stereo_upmix_gain_fir_saturate_unit regression: fail");
        $finish;
    end

    // Receiver. A rising edge on hold_req starts a long hold-off, counted
    // here, during which out_ready stays low whatever the stall rate says.
    // Since the block holds one finished result and works on the next, a
    // hold-off of several request times backs it up until in_ready drops.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            hold_left  <= 0;
            hold_req_q <= 1'b0;
        end
        else
        begin
            hold_req_q <= hold_req;
            if (hold_req && !hold_req_q)
            begin
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Samples: full-scale values, silence, small values near zero and a
    // large share of fully random patterns so that every bit toggles.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] s;
        case ($urandom_range(9))
            0:       s = S_MAX;
            1:       s = S_MIN;
            2:       s = '0;
            3:       s = SAMPLE_W'($urandom_range(8191) - 4096);
            default: s = SAMPLE_W'($urandom);
        endcase
        return s;
    endfunction

    // Gains: realistic values within plus or minus unity half of the time, some
    // extremes and some arbitrary patterns, which the clamp has to catch.
    function automatic logic [GAIN_W-1:0] pick_gain();
        logic [GAIN_W-1:0] g;
        case ($urandom_range(7))
            0:       g = GAIN_W'($urandom);
            1:       g = GAIN_MAX;
            2:       g = GAIN_MIN;
            3:       g = GAIN_NEG_LSB;
            default: g = GAIN_W'($urandom_range(4194304) - 2097152);
        endcase
        return g;
    endfunction

    // Offers one stereo pair and returns at the edge where it is accepted.
    // Valid is left high afterwards so that back-to-back requests never see
    // it lowered and raised in one time step; an idle gap lowers it first.
    // Gaps are long enough to land anywhere within the block's processing.
    task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r);
        int gap;
        gap = 0;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(2 * ITEM_CYCLES, 1);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        left_sample  <= l;
        right_sample <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pairs_sent++;
    endtask

    // Register write request; the caller lowers cfg_valid after a batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_writes++;
    endtask

    // Stops offering pairs and waits until every predicted result is back,
    // so that the registers can be rewritten with the block idle. The first
    // edge lets the count take in a pair accepted at the calling edge.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                    phase, n, ch, mode;
        logic [CFG_DATA_W-1:0] lpf_data;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: default gains and the filter running. The pairs
        // cover full scale on both inputs, opposite signs and silence. The
        // first request also waits out the history clearing after reset.
        send_pair('0, '0);
        send_pair(S_MAX, S_MAX);
        send_pair(S_MIN, S_MIN);
        send_pair(S_MAX, S_MIN);
        send_pair(S_MIN, S_MAX);
        send_pair(24'sd1, -24'sd1);
        send_pair('0, '0);
        send_pair(-24'sd1, 24'sd1);
        wait_idle();

        // Extreme gains with the filter bypassed. The enable is written with
        // every upper bit set and bit 0 clear, so the upper bits must be
        // dropped. Both spare indexes are written and must change nothing.
        write_reg(REG_FL_GAINS, {GAIN_MIN, GAIN_MAX});
        write_reg(REG_FR_GAINS, {GAIN_MAX, GAIN_MIN});
        write_reg(REG_SL_GAINS, {GAIN_MIN, GAIN_MIN});
        write_reg(REG_SR_GAINS, {GAIN_NEG_LSB, GAIN_NEG_LSB});
        write_reg(REG_C_GAINS, {GAIN_MAX, GAIN_MAX});
        write_reg(REG_LPF_ENABLE, 48'hFFFF_FFFF_FFFE);
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        cfg_valid <= 1'b0;
        send_pair(S_MAX, S_MAX);
        send_pair(S_MIN, S_MIN);
        send_pair(S_MAX, '0);
        send_pair('0, S_MIN);
        send_pair(24'sd1, 24'sd1);
        send_pair(-24'sd1, -24'sd1);
        send_pair(S_MAX, S_MIN);
        send_pair('0, '0);
        wait_idle();

        // Filter back on with a stray upper bit set: a run of full-scale
        // pairs drives the filter sums into both clamps. The history kept
        // its contents while the filter was bypassed.
        write_reg(REG_SL_GAINS, '0);
        write_reg(REG_C_GAINS, {GAIN_UNITY, GAIN_UNITY});
        write_reg(REG_LPF_ENABLE, 48'h8000_0000_0001);
        cfg_valid <= 1'b0;
        send_pair(S_MAX, S_MAX);
        send_pair(S_MAX, S_MAX);
        send_pair(S_MAX, S_MAX);
        send_pair(S_MIN, S_MIN);
        send_pair(S_MIN, S_MIN);
        send_pair('0, '0);
        wait_idle();

        // Random phases. Each rewrites every register, then runs one idling
        // pattern: none, sender gaps, receiver stalls, or a little of both.
        // The filter is off in every third phase, and the third phase also
        // opens with the long receiver hold-off.
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            mode            = phase % 4;
            sender_idle_pct = (mode == 1) ? 50 : (mode == 3) ? 14 : 0;
            stall_pct      <= (mode == 2) ? 50 : (mode == 3) ? 14 : 0;

            lpf_data    = CFG_DATA_W'({$urandom, $urandom});
            lpf_data[0] = (phase % 3 != 2);
            write_reg(REG_LPF_ENABLE, lpf_data);
            for (ch = 0; ch < NUM_CH; ch++)
                write_reg(GAIN_REG[ch], {pick_gain(), pick_gain()});
            if (phase % 2 == 1)
                write_reg((phase % 4 == 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          CFG_DATA_W'({$urandom, $urandom}));
            cfg_valid <= 1'b0;

            if (phase == 2)
                hold_req <= 1'b1;
            for (n = 0; n < PHASE_PAIRS; n++)
                send_pair(pick_sample(), pick_sample());
            wait_idle();
            hold_req <= 1'b0;
        end

        // Let the output settle so that any stray result is still caught.
        stall_pct <= 0;
        repeat (ITEM_CYCLES + 8) @(posedge clk);

        $display("Run covered %0d stereo pairs and %0d register writes over %0d phases,",
                 pairs_sent, reg_writes, RAND_PHASES + 3);
        $display("filter on and off, extreme gains, stalls and a long output hold-off; %0d checked.",
                 results_checked);
        if (error_count == 0 && outstanding == 0)
            $display("stereo_upmix_gain_fir_saturate_unit regression: pass");
        else
            $display("stereo_upmix_gain_fir_saturate_unit regression: fail");
        $finish;
    end

endmodule

// ===== stereo_upmix_gain_fir_saturate_unit.f =====
hdl/sugfs_pkg.sv
hdl/sugfs_ctrl.sv
hdl/sugfs_datapath.sv
hdl/stereo_upmix_gain_fir_saturate_unit.sv
hdl/sugfs_checker.sv
verif/upmix_checker.sv
verif/tb.sv
